### rtl/dgr_pkg.sv
// Shared widths, codes and constants of the grid ray marcher.
package dgr_pkg;

	localparam int COORD_W = 6;
	localparam int POS_W = 22;
	localparam int DELTA_W = 32;
	localparam int SD_W = 40;
	localparam int CFG_W = 7;
	localparam int FACE_W = 2;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [SD_W-1:0] SD_MAX = '1;
	localparam logic [CFG_W-1:0] CFG_RESET_DIM = 7'd64;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_CAST = 1'b1;

	localparam logic REG_MAP_WIDTH = 1'b0;
	localparam logic REG_MAP_HEIGHT = 1'b1;

	localparam logic [FACE_W-1:0] FACE_X_PAST = 2'd0;
	localparam logic [FACE_W-1:0] FACE_X_AHEAD = 2'd1;
	localparam logic [FACE_W-1:0] FACE_Y_PAST = 2'd2;
	localparam logic [FACE_W-1:0] FACE_Y_AHEAD = 2'd3;

	typedef enum logic [1:0] {
		ST_WALL = 2'd0,
		ST_LEFT = 2'd1,
		ST_LIMIT = 2'd2
	} status_t;

endpackage

### rtl/dgr_cmd_if.sv
// Command channel: map cell writes and ray casts.
interface dgr_cmd_if;
	logic valid;
	logic ready;
	logic mode;
	logic [dgr_pkg::COORD_W-1:0] cell_x;
	logic [dgr_pkg::COORD_W-1:0] cell_y;
	logic cell_wall;
	logic [dgr_pkg::POS_W-1:0] pos_x;
	logic [dgr_pkg::POS_W-1:0] pos_y;
	logic dir_x_negative;
	logic dir_y_negative;
	logic [dgr_pkg::DELTA_W-1:0] delta_x;
	logic [dgr_pkg::DELTA_W-1:0] delta_y;

	modport source (
		output valid, mode, cell_x, cell_y, cell_wall, pos_x, pos_y,
			dir_x_negative, dir_y_negative, delta_x, delta_y,
		input ready
	);
	modport sink (
		input valid, mode, cell_x, cell_y, cell_wall, pos_x, pos_y,
			dir_x_negative, dir_y_negative, delta_x, delta_y,
		output ready
	);
endinterface

### rtl/dgr_res_if.sv
// Result channel: one item per cast ray.
interface dgr_res_if;
	logic valid;
	logic ready;
	logic [dgr_pkg::COORD_W-1:0] hit_x;
	logic [dgr_pkg::COORD_W-1:0] hit_y;
	logic [dgr_pkg::FACE_W-1:0] face;
	logic [dgr_pkg::SD_W-1:0] side_dist_x;
	logic [dgr_pkg::SD_W-1:0] side_dist_y;
	logic [1:0] status;

	modport source (
		output valid, hit_x, hit_y, face, side_dist_x, side_dist_y, status,
		input ready
	);
	modport sink (
		input valid, hit_x, hit_y, face, side_dist_x, side_dist_y, status,
		output ready
	);
endinterface

### rtl/dgr_ram.sv
// Generic simple dual-port RAM with a registered read port.
module dgr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/dda_grid_ray_march.sv
// Grid map of wall bits with a DDA ray marcher, top level.
//
// The map lives in one RAM of MAP_DIM*MAP_DIM wall bits with no reset: every cell a ray
// can reach must be written before rays are cast. A write item can be accepted while a
// result waits. A ray is accepted, then the shared multiplier forms the initial x and
// then y side distances, then the walk takes one DDA step at a time, with a last check of
// the final map read or the step limit, and the result goes to the output register once
// that register is free or being read. The walk advances one cell per cycle, set by the
// map RAM's registered read being checked in the same cycle as the next step is taken.
// The next ray is accepted only when the previous one is done.
module dda_grid_ray_march #(
	parameter int MAP_DIM = 64,
	parameter int MAX_STEPS = 128,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	dgr_cmd_if.sink cmd,
	dgr_res_if.source res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [dgr_pkg::APB_AW-1:0] paddr,
	input logic [dgr_pkg::APB_DW-1:0] pwdata,
	output logic [dgr_pkg::APB_DW-1:0] prdata,
	output logic pready
);
	import dgr_pkg::*;

	localparam int XR = $clog2(MAP_DIM + 1);
	localparam int XW = ((XR > CFG_W) ? XR : CFG_W) + 1;
	localparam int OW = ((XW + FRAC_BITS > POS_W) ? XW + FRAC_BITS : POS_W) + 1;
	localparam int OFW = (FRAC_BITS + COORD_W + 1 > POS_W) ? FRAC_BITS + COORD_W + 1 : POS_W;
	localparam int PW = OFW + DELTA_W;
	localparam int DEPTH = MAP_DIM * MAP_DIM;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(MAX_STEPS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MULX,
		S_MULY,
		S_WALK,
		S_FIN
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0] map_width_q;
	logic [CFG_W-1:0] map_height_q;

	logic [POS_W-1:0] px_q, py_q;
	logic negx_q, negy_q;
	logic [DELTA_W-1:0] dx_q, dy_q;
	logic [OFW-1:0] offx_q, offy_q;
	logic signed [XW-1:0] x_q, y_q;
	logic [SD_W-1:0] sx_q, sy_q;
	logic [FACE_W-1:0] face_q;
	status_t status_q;
	logic [SW-1:0] steps_q;
	logic pend_q;

	logic rvalid_q;
	logic [COORD_W-1:0] hit_x_q, hit_y_q;
	logic [FACE_W-1:0] hit_face_q;
	logic [SD_W-1:0] out_sx_q, out_sy_q;
	status_t out_status_q;

	logic cmd_acc, cfg_wr;
	logic signed [OW-1:0] one_s, px_in, py_in, cx_in, cy_in, offx_raw, offy_raw;
	logic [OFW-1:0] offx_in, offy_in;
	logic [OFW-1:0] mul_a;
	logic [DELTA_W-1:0] mul_b;
	logic [PW-1:0] prod, prod_sh;
	logic [SD_W-1:0] scaled;
	logic signed [XW-1:0] wx, wy, step_x, step_y, nx, ny;
	logic signed [OW-1:0] px_ext, py_ext, nx_sc, ny_sc;
	logic [SD_W:0] sumx, sumy;
	logic [SD_W-1:0] sx_next, sy_next;
	logic take_x, leave, start_out, wall_hit, at_limit;
	logic [FACE_W-1:0] nface;
	logic ram_we, wall_rd;
	logic [AW-1:0] waddr, step_addr;

	assign cmd_acc = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= CFG_RESET_DIM;
			map_height_q <= CFG_RESET_DIM;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAP_WIDTH: map_width_q <= pwdata[CFG_W-1:0];
				REG_MAP_HEIGHT: map_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_MAP_WIDTH: prdata[CFG_W-1:0] = map_width_q;
			REG_MAP_HEIGHT: prdata[CFG_W-1:0] = map_height_q;
			default: prdata = '0;
		endcase
	end

	assign ram_we = cmd_acc && (cmd.mode == MODE_WRITE) && (int'(cmd.cell_x) < MAP_DIM)
		&& (int'(cmd.cell_y) < MAP_DIM);
	assign waddr = AW'(cmd.cell_y) * AW'(MAP_DIM) + AW'(cmd.cell_x);

	dgr_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_map (
		.clk(clk),
		.we(ram_we),
		.waddr(waddr),
		.wdata(cmd.cell_wall),
		.raddr(step_addr),
		.rdata(wall_rd)
	);

	// Cell offsets of the player inside the start cell, clamped at zero.
	always_comb begin
		one_s = signed'(OW'(1)) <<< FRAC_BITS;
		px_in = signed'(OW'(cmd.pos_x));
		py_in = signed'(OW'(cmd.pos_y));
		cx_in = signed'(OW'(cmd.cell_x)) <<< FRAC_BITS;
		cy_in = signed'(OW'(cmd.cell_y)) <<< FRAC_BITS;
		offx_raw = cmd.dir_x_negative ? (px_in - cx_in) : (cx_in + one_s - px_in);
		offy_raw = cmd.dir_y_negative ? (py_in - cy_in) : (cy_in + one_s - py_in);
		offx_in = offx_raw[OW-1] ? '0 : offx_raw[OFW-1:0];
		offy_in = offy_raw[OW-1] ? '0 : offy_raw[OFW-1:0];
	end

	always_comb begin
		mul_a = (state_q == S_MULX) ? offx_q : offy_q;
		mul_b = (state_q == S_MULX) ? dx_q : dy_q;
		prod = PW'(mul_a) * PW'(mul_b);
		prod_sh = prod >> FRAC_BITS;
		scaled = (|prod_sh[PW-1:SD_W]) ? SD_MAX : prod_sh[SD_W-1:0];
	end

	always_comb begin
		wx = signed'((map_width_q > MAP_DIM) ? XW'(MAP_DIM) : XW'(map_width_q));
		wy = signed'((map_height_q > MAP_DIM) ? XW'(MAP_DIM) : XW'(map_height_q));
		start_out = (x_q >= wx) || (y_q >= wy);
		take_x = sx_q < sy_q;
		step_x = negx_q ? '1 : XW'(1);
		step_y = negy_q ? '1 : XW'(1);
		nx = take_x ? (x_q + step_x) : x_q;
		ny = take_x ? y_q : (y_q + step_y);
		px_ext = signed'(OW'(px_q));
		py_ext = signed'(OW'(py_q));
		nx_sc = OW'(nx) <<< FRAC_BITS;
		ny_sc = OW'(ny) <<< FRAC_BITS;
		if (take_x) begin
			nface = (px_ext > nx_sc) ? FACE_X_PAST : FACE_X_AHEAD;
		end else begin
			nface = (py_ext > ny_sc) ? FACE_Y_PAST : FACE_Y_AHEAD;
		end
		sumx = {1'b0, sx_q} + (SD_W + 1)'(dx_q);
		sumy = {1'b0, sy_q} + (SD_W + 1)'(dy_q);
		sx_next = sumx[SD_W] ? SD_MAX : sumx[SD_W-1:0];
		sy_next = sumy[SD_W] ? SD_MAX : sumy[SD_W-1:0];
		leave = (nx < 0) || (nx >= wx) || (ny < 0) || (ny >= wy);
		step_addr = AW'(ny) * AW'(MAP_DIM) + AW'(nx);
		wall_hit = pend_q && wall_rd;
		at_limit = (steps_q == SW'(MAX_STEPS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			if (rvalid_q && res.ready && (state_q != S_FIN)) begin
				rvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc && (cmd.mode == MODE_CAST)) begin
						px_q <= cmd.pos_x;
						py_q <= cmd.pos_y;
						negx_q <= cmd.dir_x_negative;
						negy_q <= cmd.dir_y_negative;
						dx_q <= cmd.delta_x;
						dy_q <= cmd.delta_y;
						offx_q <= offx_in;
						offy_q <= offy_in;
						x_q <= signed'(XW'(cmd.cell_x));
						y_q <= signed'(XW'(cmd.cell_y));
						state_q <= S_MULX;
					end
				end
				S_MULX: begin
					sx_q <= scaled;
					state_q <= S_MULY;
				end
				S_MULY: begin
					sy_q <= scaled;
					steps_q <= '0;
					pend_q <= 1'b0;
					face_q <= FACE_X_PAST;
					if (start_out) begin
						status_q <= ST_LEFT;
						state_q <= S_FIN;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (wall_hit) begin
						status_q <= ST_WALL;
						pend_q <= 1'b0;
						state_q <= S_FIN;
					end else if (at_limit) begin
						status_q <= ST_LIMIT;
						pend_q <= 1'b0;
						state_q <= S_FIN;
					end else begin
						face_q <= nface;
						if (take_x) begin
							sx_q <= sx_next;
						end else begin
							sy_q <= sy_next;
						end
						if (leave) begin
							status_q <= ST_LEFT;
							pend_q <= 1'b0;
							state_q <= S_FIN;
						end else begin
							x_q <= nx;
							y_q <= ny;
							steps_q <= steps_q + SW'(1);
							pend_q <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (!rvalid_q || res.ready) begin
						hit_x_q <= x_q[COORD_W-1:0];
						hit_y_q <= y_q[COORD_W-1:0];
						hit_face_q <= face_q;
						out_sx_q <= sx_q;
						out_sy_q <= sy_q;
						out_status_q <= status_q;
						rvalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = rvalid_q;
	assign res.hit_x = hit_x_q;
	assign res.hit_y = hit_y_q;
	assign res.face = hit_face_q;
	assign res.side_dist_x = out_sx_q;
	assign res.side_dist_y = out_sy_q;
	assign res.status = out_status_q;
endmodule

### tb/tb_dda_grid_ray_march.sv
// Self-checking testbench for the grid ray marcher: map writes, ray casts and register settings.
`timescale 1ns / 100ps

module tb_dda_grid_ray_march;
	import dgr_pkg::*;

	localparam int MAP_DIM = 64;
	localparam int MAX_STEPS = 128;
	localparam int FRAC_BITS = 16;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_ITEMS = 155;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int MAX_PRINTS = 40;

	typedef struct {
		logic mode;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic cell_wall;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic dir_x_negative;
		logic dir_y_negative;
		logic [DELTA_W-1:0] delta_x;
		logic [DELTA_W-1:0] delta_y;
	} ray_cmd_t;

	typedef struct {
		logic [COORD_W-1:0] hit_x;
		logic [COORD_W-1:0] hit_y;
		logic [FACE_W-1:0] face;
		logic [SD_W-1:0] side_dist_x;
		logic [SD_W-1:0] side_dist_y;
		status_t status;
	} ray_hit_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	dgr_cmd_if cmd_ch();
	dgr_res_if res_ch();

	dda_grid_ray_march #(
		.MAP_DIM(MAP_DIM),
		.MAX_STEPS(MAX_STEPS),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	bit wall_map [MAP_DIM*MAP_DIM];
	logic [CFG_W-1:0] cfg_width = CFG_RESET_DIM;
	logic [CFG_W-1:0] cfg_height = CFG_RESET_DIM;

	ray_cmd_t pending_cmds [$];
	ray_hit_t expected_hits [$];
	ray_cmd_t held_cmd;
	ray_hit_t front_hit;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	int phase_w [NUM_PHASES];
	int phase_h [NUM_PHASES];
	int phase_send [NUM_PHASES];
	int phase_recv [NUM_PHASES];

	function automatic logic [63:0] side_start(longint offset, logic [63:0] delta);
		logic [63:0] prod;
		if (offset < 0)
			offset = 0;
		prod = (64'(offset) * delta) >> FRAC_BITS;
		return (prod > 64'(SD_MAX)) ? 64'(SD_MAX) : prod;
	endfunction

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > 64'(SD_MAX)) ? 64'(SD_MAX) : s;
	endfunction

	function automatic ray_hit_t trace_ray(ray_cmd_t c);
		ray_hit_t r;
		longint one, px, py;
		logic [63:0] dx, dy, sx, sy;
		int x, y, stx, sty, wx, wy, nx, ny, steps;
		bit done;
		one = longint'(1) << FRAC_BITS;
		px = longint'(c.pos_x);
		py = longint'(c.pos_y);
		dx = 64'(c.delta_x);
		dy = 64'(c.delta_y);
		wx = (int'(cfg_width) > MAP_DIM) ? MAP_DIM : int'(cfg_width);
		wy = (int'(cfg_height) > MAP_DIM) ? MAP_DIM : int'(cfg_height);
		x = int'(c.cell_x);
		y = int'(c.cell_y);
		if (c.dir_x_negative) begin
			stx = -1;
			sx = side_start(px - x * one, dx);
		end else begin
			stx = 1;
			sx = side_start((x + 1) * one - px, dx);
		end
		if (c.dir_y_negative) begin
			sty = -1;
			sy = side_start(py - y * one, dy);
		end else begin
			sty = 1;
			sy = side_start((y + 1) * one - py, dy);
		end
		r.face = FACE_X_PAST;
		r.status = ST_LIMIT;
		done = 1'b0;
		if (x >= wx || y >= wy) begin
			r.status = ST_LEFT;
		end else begin
			for (steps = 0; steps < MAX_STEPS && !done; steps++) begin
				nx = x;
				ny = y;
				if (sx < sy) begin
					sx = sat_add(sx, dx);
					nx = x + stx;
					r.face = (px > nx * one) ? FACE_X_PAST : FACE_X_AHEAD;
				end else begin
					sy = sat_add(sy, dy);
					ny = y + sty;
					r.face = (py > ny * one) ? FACE_Y_PAST : FACE_Y_AHEAD;
				end
				if (nx < 0 || nx >= wx || ny < 0 || ny >= wy) begin
					r.status = ST_LEFT;
					done = 1'b1;
				end else begin
					x = nx;
					y = ny;
					if (wall_map[y * MAP_DIM + x]) begin
						r.status = ST_WALL;
						done = 1'b1;
					end
				end
			end
		end
		r.hit_x = x[COORD_W-1:0];
		r.hit_y = y[COORD_W-1:0];
		r.side_dist_x = sx[SD_W-1:0];
		r.side_dist_y = sy[SD_W-1:0];
		return r;
	endfunction

	function automatic ray_cmd_t noise_cmd();
		ray_cmd_t c;
		c.mode = 1'($urandom_range(1, 0));
		c.cell_x = COORD_W'($urandom);
		c.cell_y = COORD_W'($urandom);
		c.cell_wall = 1'($urandom_range(1, 0));
		c.pos_x = POS_W'($urandom);
		c.pos_y = POS_W'($urandom);
		c.dir_x_negative = 1'($urandom_range(1, 0));
		c.dir_y_negative = 1'($urandom_range(1, 0));
		c.delta_x = $urandom;
		c.delta_y = $urandom;
		return c;
	endfunction

	function automatic logic [DELTA_W-1:0] pick_delta();
		case ($urandom_range(9, 0))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return 32'h10000 + $urandom_range(15 * 65536, 0);
		endcase
	endfunction

	task automatic push_write(int x, int y, bit wall);
		ray_cmd_t c;
		c = noise_cmd();
		c.mode = MODE_WRITE;
		c.cell_x = COORD_W'(x);
		c.cell_y = COORD_W'(y);
		c.cell_wall = wall;
		pending_cmds.push_back(c);
	endtask

	task automatic push_ray(int x, int y, int px, int py, bit xn, bit yn,
			logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy);
		ray_cmd_t c;
		c = noise_cmd();
		c.mode = MODE_CAST;
		c.cell_x = COORD_W'(x);
		c.cell_y = COORD_W'(y);
		c.pos_x = POS_W'(px);
		c.pos_y = POS_W'(py);
		c.dir_x_negative = xn;
		c.dir_y_negative = yn;
		c.delta_x = dx;
		c.delta_y = dy;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_random(int n);
		ray_cmd_t c;
		int eff_w, eff_h;
		eff_w = (int'(cfg_width) > MAP_DIM) ? MAP_DIM : int'(cfg_width);
		eff_h = (int'(cfg_height) > MAP_DIM) ? MAP_DIM : int'(cfg_height);
		repeat (n) begin
			c = noise_cmd();
			if (eff_w > 0 && eff_h > 0 && $urandom_range(9, 0) != 0) begin
				c.cell_x = COORD_W'($urandom_range(eff_w - 1, 0));
				c.cell_y = COORD_W'($urandom_range(eff_h - 1, 0));
			end
			if ($urandom_range(99, 0) < 30) begin
				c.mode = MODE_WRITE;
				c.cell_wall = ($urandom_range(99, 0) < 15);
			end else begin
				c.mode = MODE_CAST;
				if ($urandom_range(99, 0) < 85) begin
					c.pos_x = {c.cell_x, 16'($urandom)};
					c.pos_y = {c.cell_y, 16'($urandom)};
				end
				c.delta_x = pick_delta();
				c.delta_y = pick_delta();
			end
			pending_cmds.push_back(c);
		end
	endtask

	task automatic apb_write(logic index, logic [CFG_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * int'(index));
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == REG_MAP_WIDTH)
			cfg_width = value;
		else
			cfg_height = value;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_hits.size() != 0);
		repeat (MAX_STEPS + 16) @(negedge clk);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatch_count < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
				cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task drive_cmd(ray_cmd_t c);
		cmd_ch.mode <= c.mode;
		cmd_ch.cell_x <= c.cell_x;
		cmd_ch.cell_y <= c.cell_y;
		cmd_ch.cell_wall <= c.cell_wall;
		cmd_ch.pos_x <= c.pos_x;
		cmd_ch.pos_y <= c.pos_y;
		cmd_ch.dir_x_negative <= c.dir_x_negative;
		cmd_ch.dir_y_negative <= c.dir_y_negative;
		cmd_ch.delta_x <= c.delta_x;
		cmd_ch.delta_y <= c.delta_y;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dda_grid_ray_march regression: fail");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			drive_cmd('{default: '0});
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				if (held_cmd.mode == MODE_WRITE)
					wall_map[{held_cmd.cell_y, held_cmd.cell_x}] = held_cmd.cell_wall;
				else
					expected_hits.push_back(trace_ray(held_cmd));
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					held_cmd = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					drive_cmd(held_cmd);
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("unexpected result", 64'(res_ch.hit_x), 64'(0));
				end else begin
					front_hit = expected_hits.pop_front();
					if (res_ch.hit_x !== front_hit.hit_x)
						report_mismatch("hit_x", 64'(res_ch.hit_x), 64'(front_hit.hit_x));
					if (res_ch.hit_y !== front_hit.hit_y)
						report_mismatch("hit_y", 64'(res_ch.hit_y), 64'(front_hit.hit_y));
					if (res_ch.face !== front_hit.face)
						report_mismatch("face", 64'(res_ch.face), 64'(front_hit.face));
					if (res_ch.side_dist_x !== front_hit.side_dist_x)
						report_mismatch("side_dist_x", 64'(res_ch.side_dist_x),
							64'(front_hit.side_dist_x));
					if (res_ch.side_dist_y !== front_hit.side_dist_y)
						report_mismatch("side_dist_y", 64'(res_ch.side_dist_y),
							64'(front_hit.side_dist_y));
					if (res_ch.status !== front_hit.status)
						report_mismatch("status", 64'(res_ch.status),
							64'(front_hit.status));
				end
			end
			res_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	initial begin
		int p, i;
		phase_w = '{64, 64, 16, 1, 64, 1, 127, 0, 7, 64};
		phase_h = '{64, 64, 12, 1, 1, 64, 100, 5, 40, 64};
		phase_send = '{0, 72, 0, 14, 0, 72, 0, 14, 0, 14};
		phase_recv = '{0, 0, 72, 14, 0, 0, 72, 14, 0, 14};
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (p = 0; p < NUM_PHASES; p++) begin
			apb_write(REG_MAP_WIDTH, CFG_W'(phase_w[p]));
			apb_write(REG_MAP_HEIGHT, CFG_W'(phase_h[p]));
			@(negedge clk);
			send_idle_pct = phase_send[p];
			recv_stall_pct = phase_recv[p];
			if (p == 0) begin
				// Every cell gets a defined value before the first ray.
				for (i = 0; i < MAP_DIM * MAP_DIM; i++)
					push_write(i % MAP_DIM, i / MAP_DIM, $urandom_range(99, 0) < 12);
				push_write(18, 20, 1'b0);
				push_write(19, 20, 1'b0);
				push_write(20, 20, 1'b1);
				push_ray(17, 20, 17 * 65536 + 32768, 20 * 65536 + 32768, 1'b0, 1'b0,
					32'h10000, '1);
				push_write(30, 41, 1'b0);
				push_write(30, 40, 1'b1);
				push_ray(30, 42, 30 * 65536 + 16384, 42 * 65536 + 49152, 1'b0, 1'b1,
					'1, 32'h10000);
				push_write(0, 0, 1'b1);
				push_ray(0, 1, 4096, 65536 + 4096, 1'b1, 1'b1, '1, 32'h10000);
				push_ray(0, 0, 0, 0, 1'b1, 1'b1, '0, '0);
				push_ray(63, 63, 32'h3FFFFF, 32'h3FFFFF, 1'b0, 1'b0, '1, '1);
				// Position below the start cell, so the offset clamps to zero.
				push_ray(63, 63, 0, 0, 1'b1, 1'b1, 32'h10000, 32'h10000);
				push_ray(63, 0, 32'h3FFFFF, 0, 1'b0, 1'b1, '0, '1);
				push_ray(0, 63, 0, 32'h3FFFFF, 1'b1, 1'b0, 32'h18000, 32'h2C000);
				// Equal side distances, where the tie goes to the y step.
				push_ray(32, 32, 32 * 65536 + 32768, 32 * 65536 + 32768, 1'b0, 1'b0,
					32'd92682, 32'd92682);
				push_ray(10, 10, $urandom_range(32'h3FFFFF, 0), $urandom_range(32'h3FFFFF, 0),
					1'b0, 1'b1, pick_delta(), pick_delta());
				push_ray(40, 25, 40 * 65536 + 100, 25 * 65536 + 65000, 1'b1, 1'b0,
					32'h30000, 32'h14000);
				push_ray(5, 50, 5 * 65536 + 65535, 50 * 65536, 1'b0, 1'b1,
					32'h12345, 32'hFFFF);
				push_write(63, 63, 1'b0);
			end
			queue_random(PHASE_ITEMS / 2);
			wait_drained();
			queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			wait_drained();
		end
		if (expected_hits.size() != 0)
			report_mismatch("results never arrived", 64'(expected_hits.size()), 64'(0));
		if (mismatch_count == 0)
			$display("dda_grid_ray_march regression: pass");
		else
			$display("dda_grid_ray_march regression: fail");
		$finish;
	end

endmodule

### files.f
rtl/dgr_pkg.sv
rtl/dgr_cmd_if.sv
rtl/dgr_res_if.sv
rtl/dgr_ram.sv
rtl/dda_grid_ray_march.sv
tb/tb_dda_grid_ray_march.sv
